// ===== src/hhbf_pkg.sv =====
// Package for the HTTP Host header filter: phase codes, front-to-back beat type
// and the constant texts. No dependencies.
package hhbf_pkg;

   typedef enum logic [1:0] {
      PH_SEARCH  = 2'd0,
      PH_SKIP_CR = 2'd1,
      PH_COMPARE = 2'd2,
      PH_DONE    = 2'd3
   } phase_type;

   localparam logic [3:0] CSR_HOST_LEN    = 4'd0;
   localparam logic [3:0] CSR_HOST_WORD_0 = 4'd1;
   localparam logic [3:0] CSR_HOST_WORD_6 = 4'd7;
   localparam logic [7:0] CHAR_CR      = 8'h0d;
   localparam logic [7:0] CHAR_H       = 8'h48;
   localparam logic [7:0] PROTO_TCP    = 8'd6;

   // Classified byte handed from the front part to the back part.
   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       in_payload;
      logic [2:0] idx;
      logic       idx_small;
   } beat_type;

   function automatic logic [7:0] host_tag(input logic [2:0] p);
      logic [7:0] r;
      case (p)
         3'd0: r = "H";
         3'd1: r = "o";
         3'd2: r = "s";
         3'd3: r = "t";
         3'd4: r = ":";
         3'd5: r = " ";
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [2:0] method_size(input logic [2:0] k);
      logic [2:0] r;
      case (k)
         3'd0: r = 3'd3;
         3'd1: r = 3'd4;
         3'd2: r = 3'd4;
         3'd3: r = 3'd3;
         3'd4: r = 3'd6;
         3'd5: r = 3'd7;
         default: r = 3'd0;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] method_char(input logic [2:0] k, input logic [2:0] i);
      logic [55:0] s;
      case (k)
         3'd0: s = {"GET", 32'h0};
         3'd1: s = {"POST", 24'h0};
         3'd2: s = {"HEAD", 24'h0};
         3'd3: s = {"PUT", 32'h0};
         3'd4: s = {"DELETE", 8'h0};
         3'd5: s = "OPTIONS";
         default: s = 56'h0;
      endcase
      return s[55 - 8*i -: 8];
   endfunction

endpackage

// ===== src/http_host_block_filter_unit.sv =====
// Top level of the HTTP Host header filter: registers, front, queue, back.
// Depends on hhbf_pkg, hhbf_front, hhbf_fifo and hhbf_back.
//
//   channel | ports                         | beat
//   input   | req_push, full                | one packet byte and its last flag
//   result  | empty, rsp_pop                | verdict and http_request per packet
//   config  | csr_we, csr_index, csr_wdata  | one register write
//
// One byte a cycle is taken while full is low. A packet's last byte passes
// through the queue and then into the verdict register, from which its verdict
// can be popped. Reset is synchronous and clears the registers
// and all packet state. While a verdict waits for rsp_pop the back part goes on
// with the next packet and stalls only at its last byte; the two-entry queue
// then fills and full rises.
module http_host_block_filter_unit #(
   parameter int HOST_MAX_BYTES   = 56,
   parameter int MAX_PACKET_BYTES = 65535
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        full,
   input  logic [7:0]  req_packet_byte,
   input  logic        req_last_byte,
   output logic        empty,
   input  logic        rsp_pop,
   output logic        rsp_verdict,
   output logic        rsp_http_request,
   input  logic        csr_we,
   input  logic [3:0]  csr_index,
   input  logic [63:0] csr_wdata
);
   import hhbf_pkg::*;

   logic [5:0]  host_len_ff;
   logic [63:0] host_words_ff [7];
   logic [7:0]  host_bytes [HOST_MAX_BYTES];
   beat_type    f_beat, q_beat;
   logic        q_empty, b_ready, out_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         host_len_ff <= '0;
         for (int i = 0; i < 7; i++) host_words_ff[i] <= '0;
      end else if (csr_we) begin
         if (csr_index == CSR_HOST_LEN) host_len_ff <= csr_wdata[5:0];
         else if (csr_index <= CSR_HOST_WORD_6)
            host_words_ff[3'(csr_index - CSR_HOST_WORD_0)] <= csr_wdata;
      end
   end

   always_comb begin
      for (int k = 0; k < HOST_MAX_BYTES; k++)
         host_bytes[k] = host_words_ff[k / 8][(k % 8) * 8 +: 8];
   end

   hhbf_front #(.MAX_PACKET_BYTES(MAX_PACKET_BYTES)) u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_push && !full), .in_data(req_packet_byte),
      .in_last(req_last_byte), .beat(f_beat)
   );

   hhbf_fifo u_fifo (
      .clock(clock), .reset(reset),
      .wr_en(req_push && !full), .wr_data(f_beat), .full(full),
      .rd_en(!q_empty && b_ready), .rd_data(q_beat), .empty(q_empty)
   );

   hhbf_back #(.HOST_MAX_BYTES(HOST_MAX_BYTES)) u_back (
      .clock(clock), .reset(reset),
      .in_valid(!q_empty), .beat(q_beat), .in_ready(b_ready),
      .host_len(host_len_ff), .host_bytes(host_bytes),
      .out_valid(out_valid), .out_verdict(rsp_verdict),
      .out_http(rsp_http_request), .out_ready(rsp_pop)
   );

   assign empty = !out_valid;
endmodule

// ===== src/hhbf_front.sv =====
// Front part of the Host header filter: tracks the byte position and the IP
// and TCP header fields, marks payload bytes. Depends on hhbf_pkg.
module hhbf_front #(
   parameter int MAX_PACKET_BYTES = 65535
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic [7:0]          in_data,
   input  logic                in_last,
   output hhbf_pkg::beat_type  beat
);
   import hhbf_pkg::*;

   localparam int PW = $clog2(MAX_PACKET_BYTES + 1);

   logic [PW-1:0] pos_ff, pos_in;
   logic [5:0]    ihl_ff, ihl_in;
   logic          tcp_ff, tcp_in;
   logic [6:0]    poff_ff, poff_in;
   logic [6:0]    tcp_field;
   logic [PW-1:0] rel;
   logic          in_pay;

   always_comb begin
      tcp_field = {1'b0, ihl_ff} + 7'd12;
      ihl_in    = ihl_ff;
      tcp_in    = tcp_ff;
      poff_in   = poff_ff;
      pos_in    = pos_ff;
      in_pay    = tcp_ff && (poff_ff > tcp_field) && (pos_ff >= PW'(poff_ff));
      rel       = pos_ff - PW'(poff_ff);
      if (in_valid) begin
         if (pos_ff == '0) ihl_in = {in_data[3:0], 2'b00};
         if (pos_ff == PW'(9)) tcp_in = (in_data == PROTO_TCP);
         if (pos_ff != '0 && pos_ff == PW'(tcp_field))
            poff_in = 7'({1'b0, ihl_ff} + {1'b0, in_data[7:4], 2'b00});
         if (pos_ff != PW'(MAX_PACKET_BYTES)) pos_in = pos_ff + 1'b1;
         if (in_last) begin
            pos_in  = '0;
            ihl_in  = '0;
            tcp_in  = 1'b0;
            poff_in = '0;
         end
      end
      beat.data       = in_data;
      beat.last       = in_last;
      beat.in_payload = in_pay;
      beat.idx        = rel[2:0];
      beat.idx_small  = (rel < PW'(7));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         ihl_ff  <= '0;
         tcp_ff  <= 1'b0;
         poff_ff <= '0;
      end else begin
         pos_ff  <= pos_in;
         ihl_ff  <= ihl_in;
         tcp_ff  <= tcp_in;
         poff_ff <= poff_in;
      end
   end
endmodule

// ===== src/hhbf_fifo.sv =====
// Short queue of classified beats between the front and back parts.
// Depends on hhbf_pkg.
module hhbf_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  hhbf_pkg::beat_type wr_data,
   output logic               full,
   input  logic               rd_en,
   output hhbf_pkg::beat_type rd_data,
   output logic               empty
);
   import hhbf_pkg::*;

   beat_type   mem_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;

   always_comb begin
      wp_in  = wp_ff ^ wr_en;
      rp_in  = rp_ff ^ rd_en;
      cnt_in = cnt_ff + {1'b0, wr_en} - {1'b0, rd_en};
      full   = (cnt_ff == 2'd2);
      empty  = (cnt_ff == 2'd0);
      rd_data = mem_ff[rp_ff];
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wp_ff] <= wr_data;
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule

// ===== src/hhbf_back.sv =====
// Back part of the Host header filter: method match, Host search, host
// compare and the verdict register. Depends on hhbf_pkg.
module hhbf_back #(
   parameter int HOST_MAX_BYTES = 56
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  hhbf_pkg::beat_type  beat,
   output logic                in_ready,
   input  logic [5:0]          host_len,
   input  logic [7:0]          host_bytes [HOST_MAX_BYTES],
   output logic                out_valid,
   output logic                out_verdict,
   output logic                out_http,
   input  logic                out_ready
);
   import hhbf_pkg::*;

   localparam int HW = $clog2(HOST_MAX_BYTES);

   logic [5:0] cand_ff, cand_in;
   logic       found_ff, found_in;
   phase_type  ph_ff, ph_in;
   logic [2:0] pp_ff, pp_in;
   logic [5:0] cp_ff, cp_in;
   logic       drop_ff, drop_in;
   logic       ov_ff, ov_in, verd_ff, verd_in, http_ff, http_in;
   logic [5:0] hl;
   logic       take;
   logic [7:0] b;
   logic [5:0] cp1;
   logic [7:0] bb;

   assign hl = (host_len > 6'(HOST_MAX_BYTES)) ? 6'(HOST_MAX_BYTES) : host_len;
   // Only a last beat needs the verdict register, so other beats go on while it waits.
   assign in_ready = !ov_ff || out_ready || !beat.last;
   assign take = in_valid && in_ready;
   assign b = beat.data;
   assign cp1 = cp_ff + 6'd1;
   assign bb = (cp_ff < 6'(HOST_MAX_BYTES)) ? host_bytes[cp_ff[HW-1:0]] : 8'h00;

   always_comb begin
      logic compare_go;
      compare_go = 1'b0;
      cand_in  = cand_ff;
      found_in = found_ff;
      ph_in    = ph_ff;
      pp_in    = pp_ff;
      cp_in    = cp_ff;
      drop_in  = drop_ff;
      ov_in    = ov_ff && !out_ready;
      verd_in  = verd_ff;
      http_in  = http_ff;
      if (take) begin
         if (beat.in_payload) begin
            if (!found_ff && beat.idx_small) begin
               for (int k = 0; k < 6; k++) begin
                  if (cand_ff[k] && beat.idx < method_size(3'(k))) begin
                     if (b != method_char(3'(k), beat.idx)) cand_in[k] = 1'b0;
                     else if (beat.idx + 3'd1 == method_size(3'(k))) found_in = 1'b1;
                  end
               end
            end
            case (ph_ff)
               PH_SEARCH: begin
                  if (b == 8'h00) ph_in = PH_DONE;
                  else if (pp_ff < 3'd6 && b == host_tag(pp_ff)) begin
                     pp_in = pp_ff + 3'd1;
                     if (pp_ff == 3'd5) ph_in = PH_SKIP_CR;
                  end else pp_in = (b == CHAR_H) ? 3'd1 : 3'd0;
               end
               PH_SKIP_CR: begin
                  if (b == CHAR_CR) ;
                  else if (b == 8'h00) begin
                     drop_in = (hl == 6'd0);
                     ph_in   = PH_DONE;
                  end else begin
                     ph_in = PH_COMPARE;
                     compare_go = 1'b1;
                  end
               end
               PH_COMPARE: begin
                  if (b == CHAR_CR || b == 8'h00) ph_in = PH_DONE;
                  else compare_go = 1'b1;
               end
               default: ;
            endcase
            if (compare_go) begin
               if (cp_ff >= hl) begin
                  drop_in = 1'b1;
                  ph_in   = PH_DONE;
               end else if (b != bb) ph_in = PH_DONE;
               else begin
                  cp_in = cp1;
                  if (cp1 >= hl) begin
                     drop_in = 1'b1;
                     ph_in   = PH_DONE;
                  end
               end
            end
         end
         if (beat.last) begin
            if (ph_in == PH_SKIP_CR && hl == 6'd0) drop_in = 1'b1;
            ov_in    = 1'b1;
            verd_in  = found_in & drop_in;
            http_in  = found_in;
            cand_in  = 6'h3f;
            found_in = 1'b0;
            ph_in    = PH_SEARCH;
            pp_in    = '0;
            cp_in    = '0;
            drop_in  = 1'b0;
         end
      end
   end

   assign out_valid   = ov_ff;
   assign out_verdict = verd_ff;
   assign out_http    = http_ff;

   always_ff @(posedge clock) begin
      verd_ff <= verd_in;
      http_ff <= http_in;
      if (reset) begin
         cand_ff  <= 6'h3f;
         found_ff <= 1'b0;
         ph_ff    <= PH_SEARCH;
         pp_ff    <= '0;
         cp_ff    <= '0;
         drop_ff  <= 1'b0;
         ov_ff    <= 1'b0;
      end else begin
         cand_ff  <= cand_in;
         found_ff <= found_in;
         ph_ff    <= ph_in;
         pp_ff    <= pp_in;
         cp_ff    <= cp_in;
         drop_ff  <= drop_in;
         ov_ff    <= ov_in;
      end
   end
endmodule

// ===== bench/hhbf_checker.sv =====
// Checker for the HTTP Host header filter: watches the byte, verdict and register ports,
// predicts each packet's verdict and compares it. Depends on hhbf_pkg.
module hhbf_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic        full,
   input  logic [7:0]  req_packet_byte,
   input  logic        req_last_byte,
   input  logic        empty,
   input  logic        rsp_pop,
   input  logic        rsp_verdict,
   input  logic        rsp_http_request,
   input  logic        csr_we,
   input  logic [3:0]  csr_index,
   input  logic [63:0] csr_wdata,
   output int          mismatches,
   output int          outstanding
);
   import hhbf_pkg::*;

   typedef struct packed {
      logic verdict;
      logic http;
   } verdict_type;

   localparam int HOST_LIMIT = 56;
   localparam int POS_LIMIT  = 65535;
   localparam string HOST_TEXT = "Host: ";
   localparam string VERBS [6] = '{"GET", "POST", "HEAD", "PUT", "DELETE", "OPTIONS"};

   verdict_type verdicts_due[$];

   logic [5:0]  blk_len;
   logic [63:0] blk_words [7];

   int unsigned pos, hdr_bytes, pay_start, cmp_pos, tag_pos;
   logic        is_tcp, verb_seen, will_drop;
   logic [5:0]  verbs_live;
   phase_type   phase;

   function automatic int unsigned eff_len();
      return (blk_len > HOST_LIMIT) ? HOST_LIMIT : blk_len;
   endfunction

   function automatic logic [7:0] blk_byte(input int unsigned k);
      return blk_words[k >> 3][8 * (k & 7) +: 8];
   endfunction

   task automatic new_packet();
      pos = 0; hdr_bytes = 0; pay_start = 0; cmp_pos = 0; tag_pos = 0;
      is_tcp = 0; verb_seen = 0; will_drop = 0;
      verbs_live = 6'h3f;
      phase = PH_SEARCH;
   endtask

   task automatic host_char(input logic [7:0] b);
      if (cmp_pos >= eff_len()) begin
         will_drop = 1;
         phase = PH_DONE;
      end else if (b != blk_byte(cmp_pos)) begin
         phase = PH_DONE;
      end else begin
         cmp_pos = (cmp_pos + 1) & 6'h3f;
         if (cmp_pos >= eff_len()) begin
            will_drop = 1;
            phase = PH_DONE;
         end
      end
   endtask

   task automatic scan_host(input logic [7:0] b);
      case (phase)
         PH_SEARCH: begin
            if (b == 8'h00) begin
               phase = PH_DONE;
            end else if (tag_pos < 6 && b == HOST_TEXT[tag_pos]) begin
               tag_pos++;
               if (tag_pos == 6) phase = PH_SKIP_CR;
            end else begin
               tag_pos = (b == CHAR_H) ? 1 : 0;
            end
         end
         PH_SKIP_CR: begin
            if (b == 8'h00) begin
               will_drop = (eff_len() == 0);
               phase = PH_DONE;
            end else if (b != CHAR_CR) begin
               phase = PH_COMPARE;
               host_char(b);
            end
         end
         PH_COMPARE: begin
            if (b == CHAR_CR || b == 8'h00) phase = PH_DONE;
            else host_char(b);
         end
         default: ;
      endcase
   endtask

   task automatic match_verb(input logic [7:0] b, input int unsigned idx);
      if (verb_seen || idx >= 7) return;
      for (int k = 0; k < 6; k++) begin
         if (!verbs_live[k] || idx >= VERBS[k].len()) continue;
         if (b != VERBS[k][idx]) verbs_live[k] = 1'b0;
         else if (idx + 1 == VERBS[k].len()) verb_seen = 1;
      end
   endtask

   task automatic take_byte(input logic [7:0] b, input logic last);
      int unsigned here;
      int unsigned tcp_field;
      verdict_type v;
      here = pos;
      tcp_field = hdr_bytes + 12;
      if (here == 0) hdr_bytes = b[3:0] * 4;
      if (here == 9) is_tcp = (b == PROTO_TCP);
      if (here != 0 && here == tcp_field) pay_start = (hdr_bytes + b[7:4] * 4) & 7'h7f;
      if (is_tcp && pay_start > hdr_bytes + 12 && here >= pay_start) begin
         match_verb(b, here - pay_start);
         scan_host(b);
      end
      if (pos < POS_LIMIT) pos++;
      if (last) begin
         if (phase == PH_SKIP_CR && eff_len() == 0) will_drop = 1;
         v.verdict = verb_seen & will_drop;
         v.http = verb_seen;
         verdicts_due.push_back(v);
         new_packet();
      end
   endtask

   always @(posedge clock) begin
      verdict_type want;
      if (reset) begin
         blk_len = 0;
         foreach (blk_words[i]) blk_words[i] = 0;
         verdicts_due.delete();
         new_packet();
         mismatches = 0;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_HOST_LEN) blk_len = csr_wdata[5:0];
            else if (csr_index <= CSR_HOST_WORD_6)
               blk_words[csr_index - CSR_HOST_WORD_0] = csr_wdata;
         end
         if (req_push && !full) take_byte(req_packet_byte, req_last_byte);
         if (rsp_pop && !empty) begin
            if (verdicts_due.size() == 0) begin
               $display("%0t: verdict beat with none expected (verdict %0d http %0d)",
                        $time, rsp_verdict, rsp_http_request);
               mismatches++;
            end else begin
               want = verdicts_due.pop_front();
               if (rsp_verdict !== want.verdict) begin
                  $display("%0t: verdict expected %0d actual %0d",
                           $time, want.verdict, rsp_verdict);
                  mismatches++;
               end
               if (rsp_http_request !== want.http) begin
                  $display("%0t: http_request expected %0d actual %0d",
                           $time, want.http, rsp_http_request);
                  mismatches++;
               end
            end
         end
      end
      outstanding = verdicts_due.size();
   end

endmodule

// ===== bench/tb.sv =====
// Testbench top for the HTTP Host header filter: clock, reset, packet stimulus,
// register settings and the verdict. Depends on hhbf_pkg, hhbf_checker and the block.
module tb;
   import hhbf_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_push = 0;
   logic [7:0]  req_packet_byte = 0;
   logic        req_last_byte = 0;
   logic        rsp_pop = 0;
   logic        csr_we = 0;
   logic [3:0]  csr_index = CSR_HOST_LEN;
   logic [63:0] csr_wdata = 0;
   logic        full, empty, rsp_verdict, rsp_http_request;
   int          mismatches, outstanding;

   int          bytes_sent = 0, packets_sent = 0, verdicts_taken = 0, settings_used = 0;
   logic [7:0]  pkt [$];
   logic [7:0]  blk [56];
   int          blk_len;

   localparam string VERB_LIST [6] = '{"GET", "POST", "HEAD", "PUT", "DELETE", "OPTIONS"};

   always #5 clock = ~clock;

   http_host_block_filter_unit uut (.*);

   hhbf_checker chk (.*);

   initial begin
      #5_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Receiver: random stalls, and one long hold-off so that the block backs up.
   initial begin
      int hold;
      bit choked;
      hold = 0;
      choked = 0;
      forever begin
         @(posedge clock);
         if (rsp_pop && !empty) verdicts_taken++;
         if (!choked && verdicts_taken == 10) begin
            choked = 1;
            hold = 400;
         end
         if (hold > 0) begin
            hold--;
            rsp_pop <= 1'b0;
         end else begin
            hold = pick_gap();
            rsp_pop <= (hold == 0);
         end
      end
   end

   function automatic logic [7:0] letter();
      return 8'($urandom_range(8'h61, 8'h7a));
   endfunction

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) pkt.push_back(s[i]);
   endtask

   // Minimal header: a header length of zero puts the data offset at byte 12.
   task automatic compact(input string body, input logic [7:0] proto, input logic [3:0] doff);
      pkt.delete();
      for (int i = 0; i < 16; i++) pkt.push_back(8'($urandom));
      pkt[0] = 8'h40;
      pkt[9] = proto;
      pkt[12] = {doff, 4'h0};
      add_text(body);
   endtask

   task automatic add_host_value();
      int lim, kind, n;
      lim = (blk_len > 56) ? 56 : blk_len;
      kind = $urandom_range(0, 5);
      n = pkt.size();
      case (kind)
         0, 1, 3: for (int i = 0; i < lim; i++) pkt.push_back(blk[i]);
         2: for (int i = 0; i + 1 < lim; i++) pkt.push_back(blk[i]);
         4: repeat ($urandom_range(1, 8)) pkt.push_back(letter());
         default: ;
      endcase
      if (kind == 1) repeat ($urandom_range(1, 4)) pkt.push_back(letter());
      if (kind == 3 && lim > 0) pkt[n + $urandom_range(0, lim - 1)] ^= 8'h01;
   endtask

   task automatic make_packet();
      int ihl, doff, hdr, r;
      pkt.delete();
      if ($urandom_range(0, 99) < 8) begin
         repeat ($urandom_range(1, 30)) pkt.push_back(8'($urandom));
         return;
      end
      r = $urandom_range(0, 99);
      ihl = (r < 70) ? 5 : (r < 85) ? $urandom_range(0, 4) : $urandom_range(6, 15);
      doff = ($urandom_range(0, 9) < 8) ? $urandom_range(5, 8) : $urandom_range(0, 15);
      hdr = ihl * 4 + ((doff * 4 > 13) ? doff * 4 : 13);
      for (int i = 0; i < hdr; i++) pkt.push_back(8'($urandom));
      pkt[0] = {($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'h4, 4'(ihl)};
      pkt[9] = ($urandom_range(0, 9) != 0) ? PROTO_TCP : 8'($urandom);
      pkt[ihl * 4 + 12] = {4'(doff), 4'($urandom)};
      if ($urandom_range(0, 9) < 8) begin
         add_text(VERB_LIST[$urandom_range(0, 5)]);
         if ($urandom_range(0, 9) == 0) pkt[pkt.size() - 1] ^= 8'h20;
      end else begin
         repeat ($urandom_range(1, 6)) pkt.push_back(letter());
      end
      add_text(" / HTTP\r\n");
      r = $urandom_range(0, 9);
      if (r < 8) begin
         if ($urandom_range(0, 3) == 0) add_text("Hos");
         add_text("Host: ");
         repeat ($urandom_range(0, 2)) pkt.push_back(CHAR_CR);
         add_host_value();
         case ($urandom_range(0, 3))
            0: add_text("\r\n");
            1: pkt.push_back(8'h00);
            2: add_text("\r\nAccept: x\r\n");
            default: ;
         endcase
      end else if (r == 8) begin
         add_text("Host:x\r\n");
      end
      if ($urandom_range(0, 9) == 0) while (pkt.size() > 1 && $urandom_range(0, 7) != 0)
         void'(pkt.pop_back());
   endtask

   task automatic send_packet();
      int gap;
      for (int i = 0; i < pkt.size(); i++) begin
         req_packet_byte <= pkt[i];
         req_last_byte <= (i == pkt.size() - 1);
         req_push <= 1'b1;
         do @(posedge clock); while (full);
         bytes_sent++;
         gap = pick_gap();
         if (gap > 0) begin
            req_push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      packets_sent++;
   endtask

   // Sender waits until every verdict is back, then lets the pipeline settle.
   task automatic drain();
      req_push <= 1'b0;
      while (verdicts_taken != packets_sent) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_filter(input int len);
      logic [63:0] w;
      blk_len = len;
      csr_we <= 1'b1;
      csr_index <= CSR_HOST_LEN;
      csr_wdata <= 64'(len);
      @(posedge clock);
      for (int k = 0; k < 7; k++) begin
         for (int b = 0; b < 8; b++) w[8 * b +: 8] = blk[8 * k + b];
         csr_index <= CSR_HOST_WORD_0 + 4'(k);
         csr_wdata <= w;
         @(posedge clock);
      end
      csr_we <= 1'b0;
      @(posedge clock);
      settings_used++;
   endtask

   task automatic random_phase(input int len, input int fill);
      int start_bytes;
      foreach (blk[i]) begin
         case (fill)
            0: blk[i] = letter();
            1: blk[i] = 8'($urandom);
            2: blk[i] = 8'hff;
            default: blk[i] = 8'h00;
         endcase
      end
      set_filter(len);
      start_bytes = bytes_sent;
      while (bytes_sent - start_bytes < 110) begin
         make_packet();
         send_packet();
      end
      drain();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (blk[i]) blk[i] = letter();
      blk[0] = "a"; blk[1] = "b"; blk[2] = "c";
      set_filter(3);
      foreach (VERB_LIST[m]) begin
         compact({VERB_LIST[m], " Host: abcd\r\n"}, PROTO_TCP, 4'd4);
         send_packet();
      end
      compact("GET no host here", PROTO_TCP, 4'd4);      send_packet();
      compact("GET Host: \r\r", PROTO_TCP, 4'd4);       send_packet();
      compact("GET Host: \r\rab", PROTO_TCP, 4'd4);     send_packet();
      compact("GET Host: abc", 8'd17, 4'd4);            send_packet();
      compact("GET Host: abc", PROTO_TCP, 4'd3);        send_packet();
      compact("GETx", PROTO_TCP, 4'd4);
      pkt.push_back(8'h00);
      add_text("Host: abc");
      send_packet();
      pkt.delete();
      pkt.push_back(8'hff);
      send_packet();
      compact("GE", PROTO_TCP, 4'd4);                   send_packet();
      drain();

      random_phase(3, 0);
      random_phase(0, 0);
      random_phase(56, 0);
      random_phase(63, 0);
      random_phase(8, 1);
      random_phase(5, 2);
      random_phase(4, 3);
      random_phase($urandom_range(1, 12), 0);

      $display("Sent %0d bytes in %0d packets over %0d filter settings.",
               bytes_sent, packets_sent, settings_used);
      $display("Covered all methods, missing and empty hosts, odd headers and truncation.");
      if (mismatches == 0 && outstanding == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
